### design/earliest_due_timer_scheduler_assert.svh
// assertion macros shared by the scheduler rtl
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef EARLIEST_DUE_TIMER_SCHEDULER_ASSERT_SVH
`define EARLIEST_DUE_TIMER_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every rising clock edge outside reset
`define EDTS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define EDTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EDTS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define EDTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### design/edts_pkg.sv
// types and constants of the earliest due timer scheduler
// depends on nothing
package edts_pkg;

    localparam int OCC_W  = 5;
    localparam int TIME_W = 32;
    localparam int ID_W   = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADDED      = 2'd0,
        KIND_REMOVED    = 2'd1,
        KIND_DISPATCHED = 2'd2,
        KIND_NONE       = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  due_time;
        logic [TIME_W-1:0]  period;
        logic [31:0]        handle;
        logic [ID_W-1:0]    target_id;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    result_id;
        logic [31:0]        result_handle;
        logic               failed;
        logic [OCC_W-1:0]   occupancy;
        logic [TIME_W-1:0]  now_time;
    } t_result;

    // one task slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0]  due;
        logic [TIME_W-1:0]  period;
        logic [31:0]        handle;
        logic [ID_W-1:0]    ident;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

### design/edts_ram.sv
// generic simple dual port ram, one write and one registered read port
// depends on nothing
module edts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/earliest_due_timer_scheduler.sv
// top level of the earliest due timer scheduler: sequencer, slot scan, result register
// depends on edts_pkg, edts_ram and earliest_due_timer_scheduler_assert.svh
`include "earliest_due_timer_scheduler_assert.svh"

// Holds up to DEPTH timed tasks. A command (add, remove, tick, no-op) is taken when
// start is high and busy is low. Every command walks all DEPTH slots through one
// read port of the slot memory and one compare unit, one slot per cycle: the scan
// state issues the reads, the drain state takes in the last read, the finish state
// updates the slot and builds the result, and o_strobe then shows the result for
// one cycle. The receiver cannot stall: o_strobe marks the new result on o_result,
// which holds it until the next command finishes, and a new command may already be
// taken in that same cycle. Valid marks live in flip-flops and are cleared at reset,
// so no clearing pass is needed. run_enable comes from i_cfg_we / i_cfg_wdata,
// resets to 1 and should only change while idle.
module earliest_due_timer_scheduler #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  edts_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output edts_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // control state
    logic [IDX_W-1:0]  r_idx, n_idx;          // slot being read
    logic              r_rd_vld, n_rd_vld;    // read data of r_rd_idx arrives this cycle
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_found, n_found;
    logic [DEPTH-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [edts_pkg::TIME_W-1:0] r_now, n_now;
    logic [edts_pkg::ID_W-1:0]   r_next_id, n_next_id;
    logic              r_run_en;
    logic              r_strobe, n_strobe;

    // payload
    edts_pkg::t_cmd    r_cmd, n_cmd;
    edts_pkg::t_slot   r_best, n_best;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    edts_pkg::t_result r_res, n_res;

    // slot memory ports
    logic                      ram_wr_en;
    logic [edts_pkg::SLOT_W-1:0] ram_wr_data;
    logic [edts_pkg::SLOT_W-1:0] ram_rd_data;
    edts_pkg::t_slot           rd_slot;
    edts_pkg::t_slot           wr_slot;

    // shared compare unit and reload adder
    logic                      slot_vld;
    logic                      hit;
    logic [edts_pkg::TIME_W-1:0] reload_base;
    logic [edts_pkg::TIME_W:0]   reload_sum;
    logic [edts_pkg::TIME_W-1:0] reload_due;

    edts_ram #(
        .WIDTH (edts_pkg::SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_best_idx),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    assign rd_slot  = edts_pkg::t_slot'(ram_rd_data);
    assign slot_vld = r_valid[r_rd_idx];
    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // compare unit: decides whether the slot just read beats what was found so far
    always_comb begin
        hit = 1'b0;
        if (r_rd_vld) begin
            case (r_cmd.op)
                edts_pkg::OP_ADD:    hit = !slot_vld && !r_found;
                edts_pkg::OP_REMOVE: hit = slot_vld && !r_found &&
                                           (rd_slot.ident == r_cmd.target_id);
                // strict less keeps the lowest slot on equal due times
                edts_pkg::OP_TICK:   hit = r_run_en && slot_vld && (rd_slot.due <= r_now) &&
                                           (!r_found || (rd_slot.due < r_best.due));
                default:             hit = 1'b0;
            endcase
        end
    end

    // reload of a periodic task: max(due, now) + period, saturating
    always_comb begin
        reload_base = (r_best.due > r_now) ? r_best.due : r_now;
        reload_sum  = {1'b0, reload_base} + {1'b0, r_best.period};
        reload_due  = reload_sum[edts_pkg::TIME_W] ? '1 : reload_sum[edts_pkg::TIME_W-1:0];
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_found    = r_found;
        n_valid    = r_valid;
        n_count    = r_count;
        n_now      = r_now;
        n_next_id  = r_next_id;
        n_strobe   = 1'b0;
        n_cmd      = r_cmd;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_res      = r_res;
        ram_wr_en  = 1'b0;
        wr_slot    = r_best;

        // record the winning slot as the scan goes by
        if (hit) begin
            n_found    = 1'b1;
            n_best     = rd_slot;
            n_best_idx = r_rd_idx;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_found = 1'b0;
                    // time advances first so the due test sees the new time
                    if ((i_cmd.op == edts_pkg::OP_TICK) && (r_now != '1)) begin
                        n_now = r_now + edts_pkg::TIME_W'(1);
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                if (r_idx == IDX_W'(DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_res.kind          = edts_pkg::KIND_NONE;
                n_res.result_id     = '0;
                n_res.result_handle = '0;
                n_res.failed        = 1'b0;
                case (r_cmd.op)
                    edts_pkg::OP_ADD: begin
                        n_res.kind = edts_pkg::KIND_ADDED;
                        if (r_found) begin
                            wr_slot.due         = r_cmd.due_time;
                            wr_slot.period      = r_cmd.period;
                            wr_slot.handle      = r_cmd.handle;
                            wr_slot.ident       = r_next_id;
                            ram_wr_en           = 1'b1;
                            n_valid[r_best_idx] = 1'b1;
                            n_count             = r_count + CNT_W'(1);
                            n_next_id           = r_next_id + edts_pkg::ID_W'(1);
                            n_res.result_id     = r_next_id;
                        end else begin
                            n_res.failed = 1'b1;
                        end
                    end
                    edts_pkg::OP_REMOVE: begin
                        n_res.kind      = edts_pkg::KIND_REMOVED;
                        n_res.result_id = r_cmd.target_id;
                        if (r_found) begin
                            n_valid[r_best_idx] = 1'b0;
                            n_count             = r_count - CNT_W'(1);
                        end else begin
                            n_res.failed = 1'b1;
                        end
                    end
                    edts_pkg::OP_TICK: begin
                        if (r_found) begin
                            n_res.kind          = edts_pkg::KIND_DISPATCHED;
                            n_res.result_id     = r_best.ident;
                            n_res.result_handle = r_best.handle;
                            if (r_best.period != '0) begin
                                wr_slot.due = reload_due;
                                ram_wr_en   = 1'b1;
                            end else begin
                                // one-shot task is freed
                                n_valid[r_best_idx] = 1'b0;
                                n_count             = r_count - CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                        n_res.kind = edts_pkg::KIND_NONE;
                    end
                endcase
                n_res.occupancy = edts_pkg::OCC_W'(n_count);
                n_res.now_time  = r_now;
                n_strobe        = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign ram_wr_data = edts_pkg::SLOT_W'(wr_slot);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_found   <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_now     <= '0;
            r_next_id <= '0;
            r_run_en  <= 1'b1;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_rd_idx  <= n_rd_idx;
            r_found   <= n_found;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_now     <= n_now;
            r_next_id <= n_next_id;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_run_en <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
    end

    // a result shows up only right after the update cycle
    `EDTS_ASSERT_RST(a_strobe_after_finish, i_clk, i_rst_n, o_strobe |-> ($past(r_state) == ST_FINISH), "strobe without finish")
    // the fill count tracks the valid marks
    `EDTS_ASSERT_RST(a_count_matches_valid, i_clk, i_rst_n, r_count == CNT_W'($countones(r_valid)), "fill count mismatch")
    // a transfer always starts a full scan
    `EDTS_ASSERT_RST(a_accept_starts_scan, i_clk, i_rst_n, (start && !busy) |=> (r_state == ST_SCAN), "transfer did not start scan")
    // failure is only reported for add and remove
    `EDTS_ASSERT_RST(a_failed_kind, i_clk, i_rst_n, (o_strobe && o_result.failed) |-> ((o_result.kind == edts_pkg::KIND_ADDED) || (o_result.kind == edts_pkg::KIND_REMOVED)), "failed on wrong kind")

endmodule
